### rtl/core/page_frame_allocator_macros.svh
// assertion macros for the page frame allocator
// no dependencies; included by files that carry concurrent checks
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/pfa_pkg.sv
// shared constants, codes and types of the page frame allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGE_BYTES = 4096;
    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int STK_AW     = $clog2(MAX_PAGES);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PAGES);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INIT  = 2'd2
    } pfa_action_t;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_OOM  = 2'd1,
        STAT_BAD  = 2'd2,
        STAT_FULL = 2'd3
    } pfa_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAP_START = 1'b0,
        REG_HEAP_LIMIT = 1'b1
    } pfa_reg_idx_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } pfa_state_t;

    localparam logic [ADDR_W-1:0] HEAP_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'h8800_0000;

    // configuration register contents
    typedef struct packed {
        logic [ADDR_W-1:0] heap_start;
        logic [ADDR_W-1:0] heap_limit;
    } pfa_cfg_t;

    // engine status seen by the top level checks
    typedef struct packed {
        logic             busy;
        logic             push;
        logic [CNT_W-1:0] count;
    } pfa_obs_t;

endpackage

`default_nettype wire

### rtl/core/pfa_if.sv
// valid/ready channel interfaces: request, response and configuration write
// depends on pfa_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

interface pfa_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [pfa_pkg::ADDR_W-1:0] address;

    modport source (output valid, output action, output address, input ready);
    modport sink   (input valid, input action, input address, output ready);
endinterface

interface pfa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pfa_pkg::ADDR_W-1:0] page_address;
    logic [1:0]                 status;

    modport source (output valid, output page_address, output status, input ready);
    modport sink   (input valid, input page_address, input status, output ready);
endinterface

interface pfa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pfa_pkg::CFG_IDX_W-1:0] index;
    logic [pfa_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/pfa_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/pfa_regs.sv
// heap bound configuration registers
// depends on pfa_pkg and pfa_if
`timescale 1ns / 1ps
`default_nettype none

module pfa_regs (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pfa_cfg_if.sink     cfg,
    output pfa_pkg::pfa_cfg_t regs
);

    logic [pfa_pkg::ADDR_W-1:0] heap_start_reg, heap_start_next;
    logic [pfa_pkg::ADDR_W-1:0] heap_limit_reg, heap_limit_next;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // register write decode
    always_comb
    begin
        heap_start_next = heap_start_reg;
        heap_limit_next = heap_limit_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                pfa_pkg::REG_HEAP_START: heap_start_next = cfg.data;
                pfa_pkg::REG_HEAP_LIMIT: heap_limit_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= pfa_pkg::HEAP_START_RST;
            heap_limit_reg <= pfa_pkg::HEAP_LIMIT_RST;
        end
        else
        begin
            heap_start_reg <= heap_start_next;
            heap_limit_reg <= heap_limit_next;
        end
    end

    assign regs.heap_start = heap_start_reg;
    assign regs.heap_limit = heap_limit_reg;

endmodule

`default_nettype wire

### rtl/core/pfa_engine.sv
// request sequencer: free stack in ram, stack pointer, fresh page range, result register
// depends on pfa_pkg, pfa_if and pfa_ram
`timescale 1ns / 1ps
`default_nettype none

module pfa_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire pfa_pkg::pfa_cfg_t cfg_regs,
    pfa_req_if.sink    req,
    pfa_rsp_if.source  rsp,
    output pfa_pkg::pfa_obs_t obs
);

    localparam int PS  = pfa_pkg::PAGE_SHIFT;
    localparam int PW  = pfa_pkg::PFN_W;
    localparam int CW  = pfa_pkg::CNT_W;
    localparam int AW  = pfa_pkg::ADDR_W;
    localparam int SAW = pfa_pkg::STK_AW;

    pfa_pkg::pfa_state_t state_reg, state_next;

    logic [1:0]    action_reg;
    logic [AW-1:0] address_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] fresh_next_reg, fresh_next_next;
    logic [PW-1:0] fresh_low_reg, fresh_low_next;

    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_page_reg, out_page_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic          exec_go;
    logic          rd_en;
    logic          wr_en;
    logic [PW-1:0] rd_data;
    logic [CW-1:0] count_dec;
    logic [AW-1:0] res_page;
    logic [1:0]    res_status;
    logic          free_bad;
    logic [AW:0]   init_sum;
    logic [PW:0]   init_lo;
    logic [PW-1:0] init_hi;

    // stack memory, read at the top of stack while idle
    pfa_ram #(
        .WIDTH (PW),
        .DEPTH (pfa_pkg::MAX_PAGES)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[SAW-1:0]),
        .wr_data (address_reg[AW-1:PS]),
        .rd_en   (rd_en),
        .rd_addr (count_dec[SAW-1:0]),
        .rd_data (rd_data)
    );

    assign count_dec = count_reg - 1'b1;
    assign exec_go   = (state_reg == pfa_pkg::S_EXEC) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::S_IDLE: if (req.valid) state_next = pfa_pkg::S_EXEC;
            pfa_pkg::S_EXEC: if (exec_go) state_next = pfa_pkg::S_IDLE;
            default:         state_next = pfa_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready = 1'b0;
        rd_en     = 1'b0;
        case (state_reg)
            pfa_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                rd_en     = 1'b1;
            end
            pfa_pkg::S_EXEC: ;
            default: ;
        endcase
    end

    // free address check and initialize range
    assign free_bad = (address_reg[PS-1:0] != '0) || (address_reg < cfg_regs.heap_start)
                   || (address_reg >= cfg_regs.heap_limit);
    assign init_sum = {1'b0, cfg_regs.heap_start} + (AW+1)'(pfa_pkg::PAGE_BYTES - 1);
    assign init_lo  = init_sum[AW:PS];
    assign init_hi  = cfg_regs.heap_limit[AW-1:PS];

    // read-modify-write of the allocator state
    always_comb
    begin
        count_next      = count_reg;
        fresh_next_next = fresh_next_reg;
        fresh_low_next  = fresh_low_reg;
        wr_en           = 1'b0;
        res_page        = '0;
        res_status      = pfa_pkg::STAT_DONE;
        if (exec_go)
        begin
            case (action_reg)
                pfa_pkg::ACT_ALLOC:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_dec;
                        res_page   = {rd_data, {PS{1'b0}}};
                    end
                    else if (fresh_next_reg > fresh_low_reg)
                    begin
                        fresh_next_next = fresh_next_reg - 1'b1;
                        res_page        = {fresh_next_next, {PS{1'b0}}};
                    end
                    else
                    begin
                        res_status = pfa_pkg::STAT_OOM;
                    end
                end
                pfa_pkg::ACT_FREE:
                begin
                    if (free_bad)
                    begin
                        res_status = pfa_pkg::STAT_BAD;
                    end
                    else if (count_reg == pfa_pkg::MAX_COUNT)
                    begin
                        res_status = pfa_pkg::STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                pfa_pkg::ACT_INIT:
                begin
                    count_next = '0;
                    if (init_lo < {1'b0, init_hi})
                    begin
                        fresh_low_next  = init_lo[PW-1:0];
                        fresh_next_next = init_hi;
                    end
                    else
                    begin
                        fresh_low_next  = '0;
                        fresh_next_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        if (exec_go)
        begin
            out_valid_next  = 1'b1;
            out_page_next   = res_page;
            out_status_next = res_status;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pfa_pkg::S_IDLE;
            count_reg      <= '0;
            fresh_next_reg <= '0;
            fresh_low_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            fresh_next_reg <= fresh_next_next;
            fresh_low_reg  <= fresh_low_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            action_reg  <= req.action;
            address_reg <= req.address;
        end
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.page_address = out_page_reg;
    assign rsp.status       = out_status_reg;

    assign obs.busy  = (state_reg == pfa_pkg::S_EXEC);
    assign obs.push  = wr_en;
    assign obs.count = count_reg;

endmodule

`default_nettype wire

### rtl/core/page_frame_allocator.sv
// page frame allocator top level: config registers and request engine; uses pfa_pkg, pfa_if
// each request: the transfer cycle reads the stack top from ram; the exec state then,
// once the result register can take a value, updates pointers, writes a freed page
// and loads the result register; no new request is taken while in the exec state
// the result waits in the result register until the response transfer
// async active-low reset empties stack and fresh range and restores heap bounds; no ram clear
`timescale 1ns / 1ps
`default_nettype none

`include "page_frame_allocator_macros.svh"

module page_frame_allocator (
    input  wire logic clk,
    input  wire logic rst_n,
    pfa_req_if.sink   req,
    pfa_rsp_if.source rsp,
    pfa_cfg_if.sink   cfg
);

    pfa_pkg::pfa_cfg_t cfg_regs;
    pfa_pkg::pfa_obs_t obs;

    // heap bound registers
    pfa_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // request engine
    pfa_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .req      (req),
        .rsp      (rsp),
        .obs      (obs)
    );

    // checks
    `PFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, req.valid && req.ready, obs.busy, "request not taken")
    `PFA_ASSERT_NEXT(a_push_count, clk, rst_n, obs.push, obs.count == $past(obs.count) + 1'b1, "push lost")
    `PFA_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, obs.count <= pfa_pkg::MAX_COUNT, "stack overrun")
    `PFA_ASSERT_IMPLY(a_fail_zero, clk, rst_n, rsp.valid && (rsp.status != pfa_pkg::STAT_DONE), rsp.page_address == '0, "failed result with address")

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for page_frame_allocator: a directed table, then random alloc/free/init traffic
// untyped requests are checked against a private copy of the free stack and the untouched range
// depends on pfa_pkg, the pfa_if channel interfaces and the page_frame_allocator rtl

module tb;
    import pfa_pkg::*;

    // undefined action code, the block answers done and changes nothing
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TRAFFIC_PHASES = 10;
    localparam int PHASE_ITEMS    = 160;
    localparam int N_DIRECTED     = 25;

    typedef struct packed {
        logic [ADDR_W-1:0] page;
        pfa_status_t       status;
    } grant_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic              typed;
        grant_t            grant;
    } stim_row_t;

    // runs on the reset heap bounds; typed rows carry their response, the rest use the predictor
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{ACT_ALLOC, 32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_OOM}},
        '{ACT_NONE,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STAT_DONE}},
        '{ACT_FREE,  32'h8000_0000, 1'b1, '{32'h0000_0000, STAT_DONE}},
        '{ACT_ALLOC, 32'h0000_0000, 1'b1, '{32'h8000_0000, STAT_DONE}},
        '{ACT_FREE,  32'h8000_0001, 1'b1, '{32'h0000_0000, STAT_BAD}},
        '{ACT_FREE,  32'h7FFF_F000, 1'b1, '{32'h0000_0000, STAT_BAD}},
        '{ACT_FREE,  32'h8800_0000, 1'b1, '{32'h0000_0000, STAT_BAD}},
        '{ACT_FREE,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, STAT_BAD}},
        '{ACT_FREE,  32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_BAD}},
        '{ACT_FREE,  32'h87FF_F000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_FREE,  32'h8000_0FFF, 1'b1, '{32'h0000_0000, STAT_BAD}},
        '{ACT_INIT,  32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_DONE}},
        '{ACT_ALLOC, 32'h0000_0000, 1'b1, '{32'h87FF_F000, STAT_DONE}},
        '{ACT_ALLOC, 32'hFFFF_FFFF, 1'b1, '{32'h87FF_E000, STAT_DONE}},
        '{ACT_FREE,  32'h8000_0000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_FREE,  32'h8000_1000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_ALLOC, 32'h0000_0000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_ALLOC, 32'h0000_0000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_ALLOC, 32'h0000_0000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_FREE,  32'h87FF_F000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_FREE,  32'h87FF_F000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_ALLOC, 32'h0000_0000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_ALLOC, 32'h0000_0000, 1'b0, '{32'h0000_0000, STAT_DONE}},
        '{ACT_NONE,  32'h0000_0000, 1'b1, '{32'h0000_0000, STAT_DONE}},
        '{ACT_INIT,  32'hFFFF_FFFF, 1'b0, '{32'h0000_0000, STAT_DONE}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   no_idle;

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();
    pfa_cfg_if cfg_ch ();

    page_frame_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicted allocator state
    logic [ADDR_W-1:0] cfg_heap_start;
    logic [ADDR_W-1:0] cfg_heap_limit;
    logic [PFN_W-1:0]  freed_pfn [MAX_PAGES];
    logic [CNT_W-1:0]  stack_depth;
    logic [PFN_W-1:0]  fresh_top;
    logic [PFN_W-1:0]  fresh_floor;

    grant_t            grants_due [$];
    logic [ADDR_W-1:0] held_pages [$];

    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned quiet_cycles;
    int unsigned cfg_writes;
    int unsigned action_count [4];
    int unsigned status_count [4];

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // page numbers [lo, hi) covered by the heap bounds, false when the range is empty
    function automatic bit page_span(output logic [PFN_W-1:0] lo, output logic [PFN_W-1:0] hi);
        logic [ADDR_W:0] first;
        first = ({1'b0, cfg_heap_start} + (PAGE_BYTES - 1)) >> PAGE_SHIFT;
        hi    = cfg_heap_limit[ADDR_W-1:PAGE_SHIFT];
        lo    = first[PFN_W-1:0];
        return first < hi;
    endfunction

    // response of one request, advancing the predicted state
    function automatic grant_t predict_grant(input logic [1:0] act,
                                             input logic [ADDR_W-1:0] addr);
        grant_t           g;
        logic [PFN_W-1:0] lo;
        logic [PFN_W-1:0] hi;
        g.page   = '0;
        g.status = STAT_DONE;
        case (act)
            ACT_ALLOC:
            begin
                // most recently freed page first, then the untouched range downward
                if (stack_depth != '0)
                begin
                    stack_depth = stack_depth - 1'b1;
                    g.page = {freed_pfn[stack_depth[STK_AW-1:0]], {PAGE_SHIFT{1'b0}}};
                end
                else if (fresh_top > fresh_floor)
                begin
                    fresh_top = fresh_top - 1'b1;
                    g.page = {fresh_top, {PAGE_SHIFT{1'b0}}};
                end
                else
                    g.status = STAT_OOM;
            end
            ACT_FREE:
            begin
                if (addr[PAGE_SHIFT-1:0] != '0 || addr < cfg_heap_start || addr >= cfg_heap_limit)
                    g.status = STAT_BAD;
                else if (stack_depth >= MAX_COUNT)
                    g.status = STAT_FULL;
                else
                begin
                    freed_pfn[stack_depth[STK_AW-1:0]] = addr[ADDR_W-1:PAGE_SHIFT];
                    stack_depth = stack_depth + 1'b1;
                end
            end
            ACT_INIT:
            begin
                stack_depth = '0;
                if (page_span(lo, hi))
                begin
                    fresh_floor = lo;
                    fresh_top   = hi;
                end
                else
                begin
                    fresh_floor = '0;
                    fresh_top   = '0;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // aligned address inside the heap, or any aligned address when the heap is empty
    function automatic logic [ADDR_W-1:0] rand_heap_page();
        logic [PFN_W-1:0] lo;
        logic [PFN_W-1:0] hi;
        if (!page_span(lo, hi))
            return $urandom & ~ADDR_W'(PAGE_BYTES - 1);
        return {PFN_W'($urandom_range(hi - 1'b1, lo)), {PAGE_SHIFT{1'b0}}};
    endfunction

    // one request transfer; valid stays high afterwards unless the next call idles
    task automatic issue(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                         input bit typed = 1'b0, input grant_t typed_grant = '0);
        grant_t g;
        while (!no_idle && $urandom_range(99) < 6)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.address <= addr;
        do @(posedge clk); while (!req_ch.ready);
        g = predict_grant(act, addr);
        if (typed)
            g = typed_grant;
        grants_due.push_back(g);
        action_count[act]++;
        status_count[g.status]++;
        if (act == ACT_ALLOC && g.status == STAT_DONE)
        begin
            held_pages.push_back(g.page);
            if (held_pages.size() > 256)
                void'(held_pages.pop_front());
        end
    endtask

    // stop sending and wait for every outstanding response
    task automatic drain_grants();
        req_ch.valid <= 1'b0;
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one config register transfer
    task automatic write_reg(input pfa_reg_idx_t idx, input logic [ADDR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == REG_HEAP_START)
            cfg_heap_start = value;
        else
            cfg_heap_limit = value;
        cfg_writes++;
    endtask

    // new heap bounds, written only once the block is idle
    task automatic set_heap(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        drain_grants();
        if ($urandom_range(1))
        begin
            write_reg(REG_HEAP_START, lo);
            write_reg(REG_HEAP_LIMIT, hi);
        end
        else
        begin
            write_reg(REG_HEAP_LIMIT, hi);
            write_reg(REG_HEAP_START, lo);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // init, then mostly alloc and free of handed-out pages, with malformed frees mixed in
    task automatic run_traffic(input int n);
        logic [ADDR_W-1:0] addr;
        int unsigned       pick;
        int unsigned       k;
        issue(ACT_INIT, $urandom);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                issue(ACT_ALLOC, $urandom);
            else if (pick < 72)
            begin
                // give back a page handed out earlier
                if (held_pages.size() != 0)
                begin
                    k    = $urandom_range(held_pages.size() - 1);
                    addr = held_pages[k];
                    held_pages.delete(k);
                end
                else
                    addr = rand_heap_page();
                issue(ACT_FREE, addr);
            end
            else if (pick < 82)
                issue(ACT_FREE, rand_heap_page());
            else if (pick < 92)
            begin
                // unaligned, out of range or boundary addresses
                case ($urandom_range(4))
                    0:       addr = $urandom;
                    1:       addr = cfg_heap_limit;
                    2:       addr = cfg_heap_start - ADDR_W'(PAGE_BYTES);
                    3:       addr = rand_heap_page() | ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
                    default: addr = cfg_heap_start;
                endcase
                issue(ACT_FREE, addr);
            end
            else if (pick < 96)
                issue(ACT_INIT, $urandom);
            else
                issue(ACT_NONE, $urandom);
            // sometimes hold off until every response is back
            if ($urandom_range(99) < 2)
                drain_grants();
        end
    endtask

    // response side stalls
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    // compare each response transfer with the oldest prediction
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_checked++;
            if (grants_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: response with nothing outstanding: page %h status %0d",
                             rsp_ch.page_address, rsp_ch.status);
            end
            else
            begin
                want = grants_due.pop_front();
                if (rsp_ch.page_address !== want.page || rsp_ch.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tb: response %0d: page %h expected %h, status %0d expected %0d",
                                 results_checked, rsp_ch.page_address, want.page,
                                 rsp_ch.status, want.status);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL page_frame_allocator");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        req_ch.valid   <= 1'b0;
        req_ch.action  <= ACT_ALLOC;
        req_ch.address <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_HEAP_START;
        cfg_ch.data    <= '0;
        cfg_heap_start = HEAP_START_RST;
        cfg_heap_limit = HEAP_LIMIT_RST;
        stack_depth    = '0;
        fresh_top      = '0;
        fresh_floor    = '0;
        no_idle        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table on the reset heap bounds
        for (int i = 0; i < N_DIRECTED; i++)
            issue(DIRECTED[i].action, DIRECTED[i].address, DIRECTED[i].typed, DIRECTED[i].grant);

        // corner heap bounds first, then random ones; one phase runs without stalls
        for (int p = 0; p < TRAFFIC_PHASES; p++)
        begin
            case (p)
                0: begin lo = 32'h0000_0000; hi = 32'hFFFF_FFFF; end
                1: begin lo = 32'h0000_0000; hi = 32'h0000_3000; end
                2: begin lo = 32'h1234_5678; hi = 32'h1234_9000; end
                3: begin lo = 32'hFFFF_F001; hi = 32'hFFFF_FFFF; end
                4: begin lo = 32'h9000_0000; hi = 32'h8000_0000; end
                5: begin lo = 32'hFFFF_FFFF; hi = 32'h0000_0000; end
                default:
                begin
                    lo = $urandom_range(1) ? ($urandom & ~ADDR_W'(PAGE_BYTES - 1)) : $urandom;
                    hi = $urandom_range(3) != 0 ? lo + $urandom_range(64 * PAGE_BYTES) : $urandom;
                end
            endcase
            set_heap(lo, hi);
            no_idle = (p == 6);
            run_traffic(PHASE_ITEMS);
        end

        // back to reset bounds: edge frees, repeated frees of one page, then re-init
        set_heap(HEAP_START_RST, HEAP_LIMIT_RST);
        no_idle = 1'b1;
        issue(ACT_INIT, '0);
        issue(ACT_FREE, rand_heap_page());
        issue(ACT_FREE, HEAP_START_RST | 32'h1);
        issue(ACT_FREE, HEAP_LIMIT_RST - ADDR_W'(PAGE_BYTES));
        repeat (3) issue(ACT_ALLOC, '0);
        issue(ACT_FREE, HEAP_START_RST);
        issue(ACT_FREE, HEAP_START_RST);
        issue(ACT_FREE, HEAP_START_RST);
        issue(ACT_FREE, HEAP_START_RST);
        issue(ACT_INIT, '0);
        issue(ACT_ALLOC, '0);
        no_idle = 1'b0;

        // wait out the last responses
        drain_grants();
        repeat (8) @(posedge clk);

        $display("tb: %0d requests (%0d alloc, %0d free, %0d init, %0d undefined), %0d reg writes",
                 action_count[0] + action_count[1] + action_count[2] + action_count[3],
                 action_count[ACT_ALLOC], action_count[ACT_FREE], action_count[ACT_INIT],
                 action_count[ACT_NONE], cfg_writes);
        $display("tb: %0d responses: %0d out of memory, %0d bad address, %0d stack full; %0d wrong",
                 results_checked, status_count[STAT_OOM], status_count[STAT_BAD],
                 status_count[STAT_FULL], mismatch_count + grants_due.size());
        if (mismatch_count == 0 && grants_due.size() == 0)
            $display("PASS page_frame_allocator");
        else
            $display("FAIL page_frame_allocator");
        $finish;
    end

endmodule
